/* rtl/tcp_segment_send_decision_defines.svh */
// Assertion macros shared by the send decision RTL.
`ifndef TCP_SEGMENT_SEND_DECISION_DEFINES_SVH
`define TCP_SEGMENT_SEND_DECISION_DEFINES_SVH

// Antecedent holds, consequent holds in the same cycle.
`define TSSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcp send decision check failed");

// Antecedent holds, consequent holds in the next cycle.
`define TSSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcp send decision check failed");

`endif

/* rtl/tcpssd_pkg.sv */
// Types and constants of the TCP segment send decision block.
package tcpssd_pkg;

   localparam logic [3:0] CONN_LISTEN    = 4'd1;
   localparam logic [3:0] CONN_SYN_SENT  = 4'd2;
   localparam logic [3:0] CONN_FINWAIT1  = 4'd5;
   localparam logic [3:0] CONN_TIME_WAIT = 4'd10;

   localparam int FLAG_FORCE  = 0;
   localparam int FLAG_SYNACK = 1;
   localparam int FLAG_FINQ   = 2;

   localparam logic [2:0] CSR_INITIAL_SEQ    = 3'd0;
   localparam logic [2:0] CSR_MAX_SEG_SIZE   = 3'd1;
   localparam logic [2:0] CSR_ALLOW_SYN_DATA = 3'd2;
   localparam logic [2:0] CSR_MIN_TIMEOUT    = 3'd3;

   localparam logic [15:0] MSS_RESET     = 16'd536;
   localparam logic [15:0] MIN_TO_RESET  = 16'd500;
   localparam logic [15:0] BACKOFF_ONE   = 16'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TIMER,
      ST_SEG
   } tcpssd_state_type;

   // Per-request context seen by the segment unit.
   typedef struct packed {
      logic [31:0] una;
      logic [15:0] wnd;
      logic [19:0] cwnd;
      logic [15:0] cnt;
      logic [15:0] qlen;
      logic [3:0]  st;
      logic        synack;
      logic [31:0] iss;
      logic [15:0] mss;
      logic        allow_syn;
   } tcpssd_ctx_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] dlen;
      logic [3:0]  flags;
      logic [31:0] ptr_after;
      logic [31:0] high_after;
      logic [15:0] resent;
      logic        timer_set;
   } tcpssd_seg_type;

endpackage

/* rtl/tcpssd_seg.sv */
// Segment unit: sizes and flags one segment from the current send pointers.
module tcpssd_seg
   import tcpssd_pkg::*;
(
   input  tcpssd_ctx_type ctx,
   input  logic [31:0]    ptr,
   input  logic [31:0]    nxt,
   input  logic           force_one,
   output tcpssd_seg_type seg,
   output logic           brk
);

   logic [31:0] sent, off, gap, ptr_new;
   logic [19:0] win, usable;
   logic [15:0] avail, m1, m2, s2, s3, d1, d2, got, qrem;
   logic        at_iss, syn, fin, psh, ack, behind;

   function automatic logic ptr_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   always_comb begin
      sent = ptr - ctx.una;
      win = ({4'b0, ctx.wnd} < ctx.cwnd) ? {4'b0, ctx.wnd} : ctx.cwnd;
      if ({12'b0, win} > sent) begin
         usable = win - sent[19:0];
      end else if (win == 20'd0 && sent == 32'd0) begin
         usable = 20'd1;
      end else begin
         usable = 20'd0;
      end
      avail = (sent <= {16'b0, ctx.cnt}) ? ctx.cnt - sent[15:0] : 16'd0;
      m1 = ({4'b0, avail} < usable) ? avail : usable[15:0];
      m2 = (m1 < ctx.mss) ? m1 : ctx.mss;

      // Nagle: hold back a short segment while data is in flight.
      if (!force_one && sent != 32'd0 && m2 < ctx.mss &&
          !(ctx.st == CONN_FINWAIT1 && m2 == avail)) begin
         s2 = 16'd0;
      end else begin
         s2 = m2;
      end

      at_iss = (ptr == ctx.iss);
      if (!ctx.synack && !ctx.allow_syn) begin
         s3 = (at_iss && s2 != 16'd0) ? 16'd1 : 16'd0;
      end else begin
         s3 = s2;
      end
      brk = (s3 == 16'd0) && !force_one;

      syn = !ctx.synack && at_iss;
      d1 = (syn && s3 != 16'd0) ? s3 - 16'd1 : s3;
      off = (!ctx.synack && sent != 32'd0) ? sent - 32'd1 : sent;
      qrem = ctx.qlen - off[15:0];
      if (off < {16'b0, ctx.qlen}) begin
         got = (qrem < d1) ? qrem : d1;
      end else begin
         got = 16'd0;
      end
      fin = (d1 != 16'd0) && (got != d1);
      d2 = fin ? d1 - 16'd1 : d1;
      psh = (d2 != 16'd0) && (({1'b0, sent} + {17'b0, s3}) == {17'b0, ctx.cnt});
      ack = (ctx.st != CONN_SYN_SENT);

      behind = ptr_before(ptr, nxt);
      gap = nxt - ptr;
      ptr_new = ptr + {16'b0, s3};

      seg.seq = ptr;
      seg.dlen = d2;
      seg.flags = {ack, psh, fin, syn};
      seg.ptr_after = ptr_new;
      seg.high_after = ptr_before(nxt, ptr_new) ? ptr_new : nxt;
      if (behind) begin
         seg.resent = (gap < {16'b0, s3}) ? gap[15:0] : s3;
      end else begin
         seg.resent = 16'd0;
      end
      seg.timer_set = (s3 != 16'd0);
   end

endmodule

/* rtl/tcpssd_rto.sv */
// Retransmit timeout unit: iterative 1.25x backoff, then one multiply.
module tcpssd_rto
   import tcpssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [4:0]  backoff,
   input  logic [23:0] srtt,
   input  logic [23:0] mdev,
   input  logic [15:0] min_to,
   output logic        done,
   output logic [31:0] rto_ms
);

   logic        run_ff, run_in, done_ff, done_in;
   logic [4:0]  n_ff, n_in;
   logic [15:0] b_ff, b_in;
   logic [26:0] sum_ff, sum_in;
   logic [42:0] prod_ff, prod_in;
   logic [18:0] b5;
   logic [34:0] scaled;
   logic [31:0] sat;

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      n_in = n_ff;
      b_in = b_ff;
      sum_in = sum_ff;
      prod_in = prod_ff;
      b5 = {1'b0, b_ff, 2'b0} + {3'b0, b_ff};
      if (start) begin
         run_in = 1'b1;
         n_in = backoff;
         b_in = BACKOFF_ONE;
         sum_in = {1'b0, mdev, 2'b0} + {3'b0, srtt};
      end else if (run_ff) begin
         if (n_ff != 5'd0) begin
            b_in = (b5[18:2] > 17'h0FFFF) ? 16'hFFFF : b5[17:2];
            n_in = n_ff - 5'd1;
         end else begin
            prod_in = {27'b0, b_ff} * {16'b0, sum_ff};
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
      scaled = prod_ff[42:8];
      sat = (scaled[34:32] != 3'd0) ? 32'hFFFF_FFFF : scaled[31:0];
      rto_ms = (sat < {16'b0, min_to}) ? {16'b0, min_to} : sat;
      done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      b_ff <= b_in;
      sum_ff <= sum_in;
      prod_ff <= prod_in;
   end

endmodule

/* rtl/tcp_segment_send_decision.sv */
// Top level of the TCP segment send decision block.
// A request is taken when start is high and busy is low. The block first
// works out the retransmit timeout, then sizes one segment per cycle in a
// shared segment unit. Each segment is shown for one cycle with rsp_strobe;
// the receiver cannot stall, so results leave as soon as they are known. A
// segment is delivered in the cycle after the next one is sized, so last_seg
// is known when it is shown. Closed, listen and unknown states produce no
// segments and leave the block ready at once.
// Configuration writes are always taken and should be made while idle.
module tcp_segment_send_decision
   import tcpssd_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_unacked_seq,
   input  logic [31:0] req_next_send_seq,
   input  logic [31:0] req_highest_sent_seq,
   input  logic [15:0] req_offered_window,
   input  logic [19:0] req_congestion_window,
   input  logic [15:0] req_queued_count,
   input  logic [3:0]  req_conn_state,
   input  logic [2:0]  req_flag_bits,
   input  logic [4:0]  req_backoff_count,
   input  logic [23:0] req_smoothed_rtt,
   input  logic [23:0] req_rtt_deviation,
   output logic        rsp_strobe,
   output logic [31:0] rsp_seg_seq,
   output logic [15:0] rsp_data_len,
   output logic [3:0]  rsp_seg_flags,
   output logic [31:0] rsp_ptr_after,
   output logic [31:0] rsp_high_after,
   output logic [15:0] rsp_resent_add,
   output logic [31:0] rsp_timeout_ms,
   output logic        rsp_timer_set,
   output logic        rsp_last_seg,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   tcpssd_state_type state_ff, state_in;
   logic [31:0] iss_ff, iss_in;
   logic [15:0] mss_ff, mss_in;
   logic        allow_ff, allow_in;
   logic [15:0] minto_ff, minto_in;

   tcpssd_ctx_type ctx_ff, ctx_in;
   logic [31:0] ptr_ff, ptr_in, nxt_ff, nxt_in;
   logic        force_ff, force_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        pend_ff, pend_in;
   tcpssd_seg_type held_ff, held_in, seg;
   logic        brk;

   logic        strobe_ff, strobe_in, last_ff, last_in;
   tcpssd_seg_type out_ff, out_in;
   logic [31:0] tmo_ff, tmo_in;

   logic        accept, st_valid, rto_done;
   logic [15:0] q0, q1;
   logic [31:0] rto_ms;
   tcpssd_ctx_type ctx_use;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign st_valid = (req_conn_state > CONN_LISTEN) && (req_conn_state <= CONN_TIME_WAIT);

   always_comb begin
      ctx_use = ctx_ff;
      ctx_use.iss = iss_ff;
      ctx_use.mss = mss_ff;
      ctx_use.allow_syn = allow_ff;
   end

   tcpssd_seg u_seg (
      .ctx       (ctx_use),
      .ptr       (ptr_ff),
      .nxt       (nxt_ff),
      .force_one (force_ff),
      .seg       (seg),
      .brk       (brk)
   );

   tcpssd_rto u_rto (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && st_valid),
      .backoff (req_backoff_count),
      .srtt    (req_smoothed_rtt),
      .mdev    (req_rtt_deviation),
      .min_to  (minto_ff),
      .done    (rto_done),
      .rto_ms  (rto_ms)
   );

   // Configuration registers.
   always_comb begin
      iss_in = iss_ff;
      mss_in = mss_ff;
      allow_in = allow_ff;
      minto_in = minto_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INITIAL_SEQ:    iss_in = csr_wdata;
            CSR_MAX_SEG_SIZE:   mss_in = csr_wdata[15:0];
            CSR_ALLOW_SYN_DATA: allow_in = csr_wdata[0];
            CSR_MIN_TIMEOUT:    minto_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      ctx_in = ctx_ff;
      ptr_in = ptr_ff;
      nxt_in = nxt_ff;
      force_in = force_ff;
      count_in = count_ff;
      pend_in = pend_ff;
      held_in = held_ff;
      strobe_in = 1'b0;
      last_in = 1'b0;
      out_in = held_ff;
      tmo_in = held_ff.timer_set ? rto_ms : 32'd0;

      q0 = req_flag_bits[FLAG_SYNACK] ? req_queued_count :
           (req_queued_count != 16'd0 ? req_queued_count - 16'd1 : 16'd0);
      q1 = (req_flag_bits[FLAG_FINQ] && q0 != 16'd0) ? q0 - 16'd1 : q0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && st_valid) begin
               ctx_in.una = req_unacked_seq;
               ctx_in.wnd = req_offered_window;
               ctx_in.cwnd = req_congestion_window;
               ctx_in.cnt = req_queued_count;
               ctx_in.qlen = q1;
               ctx_in.st = req_conn_state;
               ctx_in.synack = req_flag_bits[FLAG_SYNACK];
               ptr_in = req_next_send_seq;
               nxt_in = req_highest_sent_seq;
               force_in = req_flag_bits[FLAG_FORCE];
               count_in = '0;
               pend_in = 1'b0;
               state_in = ST_TIMER;
            end
         end
         ST_TIMER: begin
            if (rto_done) begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (count_ff == CNT_W'(MAX_SEGMENTS) || brk) begin
               // The run ends: the held segment, if any, is the last one.
               strobe_in = pend_ff;
               last_in = 1'b1;
               pend_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               strobe_in = pend_ff;
               held_in = seg;
               pend_in = 1'b1;
               ptr_in = seg.ptr_after;
               nxt_in = seg.high_after;
               force_in = 1'b0;
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iss_ff <= 32'd0;
         mss_ff <= MSS_RESET;
         allow_ff <= 1'b0;
         minto_ff <= MIN_TO_RESET;
         pend_ff <= 1'b0;
         count_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff <= iss_in;
         mss_ff <= mss_in;
         allow_ff <= allow_in;
         minto_ff <= minto_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         strobe_ff <= strobe_in;
      end
      ctx_ff <= ctx_in;
      ptr_ff <= ptr_in;
      nxt_ff <= nxt_in;
      force_ff <= force_in;
      held_ff <= held_in;
      last_ff <= last_in;
      out_ff <= out_in;
      tmo_ff <= tmo_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_seg_seq = out_ff.seq;
   assign rsp_data_len = out_ff.dlen;
   assign rsp_seg_flags = out_ff.flags;
   assign rsp_ptr_after = out_ff.ptr_after;
   assign rsp_high_after = out_ff.high_after;
   assign rsp_resent_add = out_ff.resent;
   assign rsp_timeout_ms = tmo_ff;
   assign rsp_timer_set = out_ff.timer_set;
   assign rsp_last_seg = last_ff;

`include "tcp_segment_send_decision_defines.svh"

   `TSSD_ASSERT_SAME(a_pend_in_seg, clock, reset, pend_ff, state_ff == ST_SEG)
   `TSSD_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_strobe && rsp_last_seg, !rsp_strobe)
   `TSSD_ASSERT_SAME(a_count_bound, clock, reset, state_ff == ST_SEG,
                     count_ff <= CNT_W'(MAX_SEGMENTS))
   `TSSD_ASSERT_NEXT(a_accept_busy, clock, reset, accept && st_valid, busy)

endmodule

/* sim/tcp_segment_send_decision_tb.sv */
// Self-checking testbench for the TCP segment send decision block.
`timescale 1ns / 100ps

module tcp_segment_send_decision_tb
   import tcpssd_pkg::*;
();

   localparam int MAX_SEGS   = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int NUM_RANDOM = 180;

   localparam logic [3:0] CONN_CLOSED   = 4'd0;
   localparam logic [3:0] CONN_SYN_RCVD = 4'd3;
   localparam logic [3:0] CONN_ESTAB    = 4'd4;

   typedef struct packed {
      logic [31:0] una;
      logic [31:0] ptr;
      logic [31:0] high;
      logic [15:0] wnd;
      logic [19:0] cwnd;
      logic [15:0] cnt;
      logic [3:0]  st;
      logic [2:0]  fl;
      logic [4:0]  boff;
      logic [23:0] srtt;
      logic [23:0] mdev;
   } snapshot_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] dlen;
      logic [3:0]  flags;
      logic [31:0] ptr_after;
      logic [31:0] high_after;
      logic [15:0] resent;
      logic [31:0] timeout;
      logic        timer_set;
      logic        last;
   } segment_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   snapshot_type drv;
   logic        rsp_strobe;
   logic [31:0] rsp_seg_seq;
   logic [15:0] rsp_data_len;
   logic [3:0]  rsp_seg_flags;
   logic [31:0] rsp_ptr_after;
   logic [31:0] rsp_high_after;
   logic [15:0] rsp_resent_add;
   logic [31:0] rsp_timeout_ms;
   logic        rsp_timer_set;
   logic        rsp_last_seg;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // Shadow copy of the configuration registers.
   logic [31:0] iss_q;
   logic [15:0] mss_q;
   logic        syn_data_q;
   logic [15:0] min_to_q;

   segment_type pending_segs[$];
   int          errors;
   int          idle_cycles;
   int          seg_count;
   bit          idling_on;

   tcp_segment_send_decision #(.MAX_SEGMENTS(MAX_SEGS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_unacked_seq(drv.una), .req_next_send_seq(drv.ptr),
      .req_highest_sent_seq(drv.high), .req_offered_window(drv.wnd),
      .req_congestion_window(drv.cwnd), .req_queued_count(drv.cnt),
      .req_conn_state(drv.st), .req_flag_bits(drv.fl),
      .req_backoff_count(drv.boff), .req_smoothed_rtt(drv.srtt),
      .req_rtt_deviation(drv.mdev),
      .rsp_strobe(rsp_strobe), .rsp_seg_seq(rsp_seg_seq),
      .rsp_data_len(rsp_data_len), .rsp_seg_flags(rsp_seg_flags),
      .rsp_ptr_after(rsp_ptr_after), .rsp_high_after(rsp_high_after),
      .rsp_resent_add(rsp_resent_add), .rsp_timeout_ms(rsp_timeout_ms),
      .rsp_timer_set(rsp_timer_set), .rsp_last_seg(rsp_last_seg),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] backed_timeout(input logic [4:0] n,
                                                  input logic [23:0] srtt,
                                                  input logic [23:0] mdev);
      logic [63:0] b;
      logic [63:0] rto;
      b = 64'd256;
      for (int i = 0; i < n; i++) begin
         b = (b * 5) >> 2;
         if (b > 64'd65535) b = 64'd65535;
      end
      rto = (b * (4 * {40'd0, mdev} + {40'd0, srtt})) >> 8;
      if (rto > 64'hFFFF_FFFF) rto = 64'hFFFF_FFFF;
      if (rto < {48'd0, min_to_q}) rto = {48'd0, min_to_q};
      return rto[31:0];
   endfunction

   function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
      return a < b ? a : b;
   endfunction

   function automatic bit seq_lt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   // Works out the run of segments for one snapshot and queues them.
   task automatic predict_segments(input snapshot_type s);
      bit          force_one, synack, finq, is_syn;
      logic [63:0] qlen, sent, win, usable, avail, ssize, dsize, resent, off, got;
      logic [31:0] ptr, high;
      logic [3:0]  flags;
      segment_type seg;
      int          n;
      force_one = s.fl[FLAG_FORCE];
      synack = s.fl[FLAG_SYNACK];
      finq = s.fl[FLAG_FINQ];
      ptr = s.ptr;
      high = s.high;
      n = 0;
      if (s.st <= CONN_LISTEN || s.st > CONN_TIME_WAIT) return;
      qlen = s.cnt;
      if (!synack) qlen = qlen > 0 ? qlen - 1 : 0;
      if (finq) qlen = qlen > 0 ? qlen - 1 : 0;
      while (n < MAX_SEGS) begin
         sent = {32'd0, ptr - s.una};
         win = min64(s.wnd, s.cwnd);
         if (win > sent) usable = win - sent;
         else if (win == 0 && sent == 0) usable = 1;
         else usable = 0;
         avail = sent <= s.cnt ? s.cnt - sent : 0;
         ssize = min64(min64(avail, usable), mss_q);
         if (!force_one && sent != 0 && ssize < mss_q &&
             !(s.st == CONN_FINWAIT1 && ssize == avail))
            ssize = 0;
         if (!synack && !syn_data_q)
            ssize = (ptr == iss_q) ? min64(1, ssize) : 0;
         if (ssize == 0 && !force_one) break;
         force_one = 1'b0;
         flags = (s.st != CONN_SYN_SENT) ? 4'b1000 : 4'b0000;
         dsize = ssize;
         is_syn = !synack && ptr == iss_q;
         if (is_syn) begin
            flags[0] = 1'b1;
            dsize = dsize > 0 ? dsize - 1 : 0;
         end
         if (dsize != 0) begin
            off = sent;
            if (!synack && sent != 0) off = off - 1;
            got = off < qlen ? min64(qlen - off, dsize) : 0;
            if (got != dsize) begin
               flags[1] = 1'b1;
               dsize = dsize - 1;
            end
         end
         if (dsize != 0 && sent + ssize == s.cnt) flags[2] = 1'b1;
         resent = 0;
         if (seq_lt(ptr, high)) resent = min64({32'd0, high - ptr}, ssize);
         seg.seq = ptr;
         ptr = ptr + ssize[31:0];
         if (seq_lt(high, ptr)) high = ptr;
         seg.dlen = dsize[15:0];
         seg.flags = flags;
         seg.ptr_after = ptr;
         seg.high_after = high;
         seg.resent = resent[15:0];
         seg.timeout = (ssize != 0) ? backed_timeout(s.boff, s.srtt, s.mdev) : 32'd0;
         seg.timer_set = (ssize != 0);
         seg.last = 1'b0;
         pending_segs.push_back(seg);
         n++;
      end
      if (n > 0) pending_segs[pending_segs.size() - 1].last = 1'b1;
   endtask

   // Checks every strobed segment against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         segment_type e;
         if (pending_segs.size() == 0) begin
            $error("unexpected segment seq=%h", rsp_seg_seq);
            errors++;
         end else begin
            e = pending_segs.pop_front();
            seg_count++;
            if (rsp_seg_seq !== e.seq) begin
               $error("seg_seq exp %h got %h", e.seq, rsp_seg_seq); errors++;
            end
            if (rsp_data_len !== e.dlen) begin
               $error("data_len exp %0d got %0d", e.dlen, rsp_data_len); errors++;
            end
            if (rsp_seg_flags !== e.flags) begin
               $error("seg_flags exp %h got %h", e.flags, rsp_seg_flags); errors++;
            end
            if (rsp_ptr_after !== e.ptr_after) begin
               $error("ptr_after exp %h got %h", e.ptr_after, rsp_ptr_after); errors++;
            end
            if (rsp_high_after !== e.high_after) begin
               $error("high_after exp %h got %h", e.high_after, rsp_high_after);
               errors++;
            end
            if (rsp_resent_add !== e.resent) begin
               $error("resent_add exp %0d got %0d", e.resent, rsp_resent_add); errors++;
            end
            if (rsp_timeout_ms !== e.timeout) begin
               $error("timeout_ms exp %0d got %0d", e.timeout, rsp_timeout_ms); errors++;
            end
            if (rsp_timer_set !== e.timer_set) begin
               $error("timer_set exp %b got %b", e.timer_set, rsp_timer_set); errors++;
            end
            if (rsp_last_seg !== e.last) begin
               $error("last_seg exp %b got %b", e.last, rsp_last_seg); errors++;
            end
         end
      end
   end

   // Watchdog: cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tcp_segment_send_decision test failed");
         $finish;
      end
   end

   // Start stays high between back-to-back transfers; a gap or a drain drops it.
   task automatic send_snapshot(input snapshot_type s);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      drv <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_segments(s);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_segs.size() != 0) @(posedge clock);
      // Idle-state items and the tail of a request can still be in flight.
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_INITIAL_SEQ:    iss_q = val;
         CSR_MAX_SEG_SIZE:   mss_q = val[15:0];
         CSR_ALLOW_SYN_DATA: syn_data_q = val[0];
         CSR_MIN_TIMEOUT:    min_to_q = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] iss, input logic [15:0] mss,
                             input logic syn_data, input logic [15:0] min_to);
      drain_results();
      write_csr(CSR_INITIAL_SEQ, iss);
      write_csr(CSR_MAX_SEG_SIZE, {16'd0, mss});
      write_csr(CSR_ALLOW_SYN_DATA, {31'd0, syn_data});
      write_csr(CSR_MIN_TIMEOUT, {16'd0, min_to});
      csr_valid <= 1'b0;
   endtask

   // Random snapshot, mostly consistent: una <= ptr <= una+cnt, small sizes.
   function automatic snapshot_type random_snapshot();
      snapshot_type s;
      s.una = $urandom();
      s.cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 7) == 0) s.ptr = $urandom();
      else s.ptr = s.una + $urandom_range(0, s.cnt);
      case ($urandom_range(0, 3))
         0: s.high = s.ptr;
         1: s.high = s.ptr + $urandom_range(0, 2000);
         2: s.high = s.ptr - $urandom_range(0, 2000);
         default: s.high = $urandom();
      endcase
      s.wnd = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
      s.cwnd = ($urandom_range(0, 5) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 5000));
      s.st = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(2, 10));
      s.fl = 3'($urandom());
      if ($urandom_range(0, 2) != 0) s.fl[FLAG_SYNACK] = 1'b1;
      s.boff = 5'($urandom());
      s.srtt = 24'($urandom());
      s.mdev = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 500));
      return s;
   endfunction

   task automatic test_directed();
      snapshot_type s;
      s = '{una: 32'd1000, ptr: 32'd1000, high: 32'd1000, wnd: 16'd4000,
            cwnd: 20'd4000, cnt: 16'd1500, st: CONN_ESTAB, fl: 3'b010,
            boff: 5'd0, srtt: 24'd100, mdev: 24'd10};
      send_snapshot(s);                    // plain bulk send
      for (int st = 0; st < 16; st++) begin
         s.st = 4'(st);
         s.fl = 3'b011;
         send_snapshot(s);                 // every state, with force
      end
      s.st = CONN_ESTAB;
      s.wnd = 16'd0; s.cwnd = 20'd0; s.fl = 3'b010;
      send_snapshot(s);                    // zero-window probe
      s.ptr = 32'd1200; s.fl = 3'b011;
      send_snapshot(s);                    // forced empty segment
      s.ptr = 32'd0; s.una = 32'd0; s.fl = 3'b100; s.cnt = 16'd0;
      s.st = CONN_SYN_SENT; s.wnd = 16'hFFFF; s.cwnd = 20'hFFFFF;
      send_snapshot(s);                    // SYN without room, FIN queued
      s.cnt = 16'hFFFF; s.fl = 3'b110; s.boff = 5'd31;
      s.srtt = 24'hFFFFFF; s.mdev = 24'hFFFFFF;
      send_snapshot(s);                    // saturated timeout, full queue
      s = '{una: 32'hFFFF_FF00, ptr: 32'h0000_0100, high: 32'hFFFF_FFFF,
            wnd: 16'd100, cwnd: 20'd100, cnt: 16'd50, st: CONN_FINWAIT1,
            fl: 3'b111, boff: 5'd3, srtt: 24'd1, mdev: 24'd0};
      send_snapshot(s);                    // pointer beyond queue
      s.ptr = 32'hFFFF_FF10; s.high = 32'h0000_0020; s.cnt = 16'd60;
      send_snapshot(s);                    // retransmission across wrap
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_snapshot(random_snapshot());
   endtask

   initial begin
      errors = 0;
      seg_count = 0;
      idling_on = 1'b1;
      start = 1'b0;
      drv = '0;
      csr_valid = 1'b0;
      csr_index = CSR_INITIAL_SEQ;
      csr_wdata = '0;
      iss_q = 32'd0;
      mss_q = MSS_RESET;
      syn_data_q = 1'b0;
      min_to_q = MIN_TO_RESET;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_config(32'd0, 16'd1, 1'b1, 16'd0);
      test_directed();
      set_config(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'hFFFF);
      test_directed();
      set_config(32'd1000, 16'd536, 1'b1, 16'd200);
      test_random(NUM_RANDOM / 4);
      set_config($urandom(), 16'($urandom_range(1, 1500)), 1'b0, 16'($urandom()));
      test_random(NUM_RANDOM / 4);
      set_config(32'd0, 16'd100, 1'b1, 16'd500);
      test_random(NUM_RANDOM / 4);
      drain_results();
      idling_on = 1'b0;
      test_random(NUM_RANDOM / 4);

      drain_results();
      $display("Covered directed corner snapshots under three register sets and %0d",
               NUM_RANDOM);
      $display("random snapshots under three more; %0d segments checked.", seg_count);
      if (errors == 0 && pending_segs.size() == 0)
         $display("tcp_segment_send_decision test passed");
      else
         $display("tcp_segment_send_decision test failed");
      $finish;
   end

endmodule
